[hw/rtl/va3d_pkg.sv]
// Package: shared types, constants and arctangent table for the vector angle unit
`timescale 1ns / 1ps
package va3d_pkg;

	localparam int COMPONENT_BITS_DEF = 16;
	localparam int FIELD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int THRESH_BITS = 32;
	localparam int CORDIC_STEPS = 21;
	localparam int STEP_BITS = 5;
	localparam int CXY_BITS = 34;
	localparam int Z_BITS = 24;
	localparam logic [Z_BITS-1:0] PI_Q20 = 24'd3294199;
	localparam logic [ANGLE_BITS-1:0] HALF_PI_Q14 = 16'd25736;
	localparam logic [ANGLE_BITS-1:0] PI_Q14 = 16'd51472;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] a_x;
		logic signed [FIELD_BITS-1:0] a_y;
		logic signed [FIELD_BITS-1:0] a_z;
		logic signed [FIELD_BITS-1:0] b_x;
		logic signed [FIELD_BITS-1:0] b_y;
		logic signed [FIELD_BITS-1:0] b_z;
	} va3d_in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic                  degenerate;
	} va3d_out_t;

	// classified word handed from front to back
	typedef struct packed {
		logic        negative;
		logic [65:0] mag;
		logic [65:0] la;
		logic [65:0] lb;
	} va3d_job_t;

	function automatic logic [Z_BITS-1:0] atan_q20(input logic [STEP_BITS-1:0] i);
		logic [Z_BITS-1:0] r;
		unique case (i)
			5'd0: r = 24'd823550;
			5'd1: r = 24'd486170;
			5'd2: r = 24'd256879;
			5'd3: r = 24'd130396;
			5'd4: r = 24'd65451;
			5'd5: r = 24'd32757;
			5'd6: r = 24'd16383;
			5'd7: r = 24'd8192;
			5'd8: r = 24'd4096;
			5'd9: r = 24'd2048;
			5'd10: r = 24'd1024;
			5'd11: r = 24'd512;
			5'd12: r = 24'd256;
			5'd13: r = 24'd128;
			5'd14: r = 24'd64;
			5'd15: r = 24'd32;
			5'd16: r = 24'd16;
			5'd17: r = 24'd8;
			5'd18: r = 24'd4;
			5'd19: r = 24'd2;
			5'd20: r = 24'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/vector_angle_3d_unit.sv]
// Top level: angle between two 3D vectors
// Path: two front-end stages, the queue, then the back-end sequencer, which takes a new word
// only when idle: partial-product multiply, 66-step root, 30-step divide, 32-step sine
// root and 21 CORDIC steps, one step a cycle; a stalled result holds the back end. The divide
// ends at once when the cosine clamps, and a degenerate word skips divide, sine root and CORDIC.
// arst_n clears all control state and sets zero_threshold to 1.
`timescale 1ns / 1ps
module vector_angle_3d_unit #(
	parameter int COMPONENT_BITS = va3d_pkg::COMPONENT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  va3d_pkg::va3d_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output va3d_pkg::va3d_out_t out_data
);
	logic [31:0]         zero_threshold_q;
	logic                f_valid, f_stall, b_valid, b_stall;
	va3d_pkg::va3d_job_t f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zero_threshold_q <= 32'd1;
		else if (cfg_we) zero_threshold_q <= cfg_wdata;
	end

	va3d_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
	);

	va3d_queue #(.DEPTH(va3d_pkg::QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
	);

	va3d_back u_back (
		.clk, .arst_n, .zero_threshold(zero_threshold_q),
		.job_valid(b_valid), .job_stall(b_stall), .job_data(b_data),
		.out_valid, .out_stall, .out_data
	);
endmodule

[hw/rtl/va3d_front.sv]
// Front end: accept input words, form dot product sign/magnitude and squared lengths
`timescale 1ns / 1ps
module va3d_front #(
	parameter int COMPONENT_BITS = va3d_pkg::COMPONENT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  va3d_pkg::va3d_in_t  in_data,
	output logic                job_valid,
	input  logic                job_stall,
	output va3d_pkg::va3d_job_t job_data
);
	localparam int CB = COMPONENT_BITS;
	localparam int PB = 2 * CB;

	logic               valid_s1, valid_s2;
	logic signed [CB-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [PB-1:0] pxx_s2, pyy_s2, pzz_s2;
	logic [PB-1:0]      aa_s2 [3];
	logic [PB-1:0]      bb_s2 [3];
	logic signed [PB+2:0] dot;
	logic               adv_s2, adv_s1;

	assign adv_s2   = !valid_s2 || !job_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			ax_s1 <= CB'({in_data.a_x});
			ay_s1 <= CB'({in_data.a_y});
			az_s1 <= CB'({in_data.a_z});
			bx_s1 <= CB'({in_data.b_x});
			by_s1 <= CB'({in_data.b_y});
			bz_s1 <= CB'({in_data.b_z});
		end
		if (adv_s2 && valid_s1) begin
			pxx_s2 <= ax_s1 * bx_s1;
			pyy_s2 <= ay_s1 * by_s1;
			pzz_s2 <= az_s1 * bz_s1;
			aa_s2[0] <= PB'(ax_s1 * ax_s1);
			aa_s2[1] <= PB'(ay_s1 * ay_s1);
			aa_s2[2] <= PB'(az_s1 * az_s1);
			bb_s2[0] <= PB'(bx_s1 * bx_s1);
			bb_s2[1] <= PB'(by_s1 * by_s1);
			bb_s2[2] <= PB'(bz_s1 * bz_s1);
		end
	end

	assign dot = (PB+3)'(pxx_s2) + (PB+3)'(pyy_s2) + (PB+3)'(pzz_s2);

	always_comb begin
		job_valid         = valid_s2;
		job_data.negative = dot[PB+2];
		job_data.mag      = dot[PB+2] ? 66'(-dot) : 66'(dot);
		job_data.la = 66'(aa_s2[0]) + 66'(aa_s2[1]) + 66'(aa_s2[2]);
		job_data.lb = 66'(bb_s2[0]) + 66'(bb_s2[1]) + 66'(bb_s2[2]);
	end
endmodule

[hw/rtl/va3d_queue.sv]
// Short queue between front and back end
`timescale 1ns / 1ps
module va3d_queue #(
	parameter int DEPTH = va3d_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_stall,
	input  va3d_pkg::va3d_job_t wr_data,
	output logic                rd_valid,
	input  logic                rd_stall,
	output va3d_pkg::va3d_job_t rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	va3d_pkg::va3d_job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end
endmodule

[hw/rtl/va3d_back.sv]
// Back end: sequencer for multiply, root, divide, sine root and CORDIC arccosine
`timescale 1ns / 1ps
module va3d_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           zero_threshold,
	input  logic                  job_valid,
	output logic                  job_stall,
	input  va3d_pkg::va3d_job_t   job_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output va3d_pkg::va3d_out_t   out_data
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ROOT, ST_CHECK, ST_DIV, ST_SIN, ST_CORDIC, ST_DONE
	} state_t;

	state_t       state_q;
	logic [6:0]   cnt_q;
	logic         neg_q;
	logic [65:0]  mag_q;
	logic [65:0]  la_q, lb_q;
	logic [131:0] prod_q;
	logic [65:0]  den_q;
	logic [67:0]  rem_q;
	logic [66:0]  r_q;
	logic [30:0]  c_q;
	logic [61:0]  sv_q;
	logic [31:0]  s_q;
	logic [63:0]  srem_q;
	logic signed [va3d_pkg::CXY_BITS-1:0] x_q, y_q;
	logic signed [va3d_pkg::Z_BITS-1:0]   z_q;
	logic         deg_q;
	logic         ovalid_q;
	va3d_pkg::va3d_out_t odata_q;

	// shift-subtract root helpers (two bits consumed per step)
	logic [69:0]  rt_rem;
	logic [67:0]  rt_trial;
	logic [65:0]  sr_trial;
	logic [65:0]  sr_rem;
	logic [67:0]  d_diff;
	logic [31:0]  mul_a, mul_b;
	logic [63:0]  pp;
	logic [7:0]   mshift;
	logic signed [va3d_pkg::CXY_BITS-1:0] ycur, dx, dy;
	logic [va3d_pkg::STEP_BITS-1:0] step;
	logic [va3d_pkg::Z_BITS:0] zf;
	logic signed [va3d_pkg::Z_BITS+1:0] zr;
	logic [va3d_pkg::ANGLE_BITS-1:0] angle_c;
	logic         degen;
	logic         emit;

	assign job_stall = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign emit      = (state_q == ST_DONE) && (!ovalid_q || !out_stall);
	assign degen     = (den_q == '0) || (den_q < 66'(zero_threshold));

	assign rt_rem   = {rem_q, prod_q[131:130]};
	assign rt_trial = {den_q, 2'b01};
	assign sr_rem   = {srem_q, sv_q[61:60]};
	assign sr_trial = 66'({s_q, 2'b01});
	assign d_diff   = {1'b0, r_q} - {2'b0, den_q};
	assign step     = cnt_q[va3d_pkg::STEP_BITS-1:0];
	assign ycur     = (cnt_q == '0) ? $signed(va3d_pkg::CXY_BITS'(s_q)) : y_q;
	assign dx       = ycur >>> step;
	assign dy       = x_q >>> step;
	assign mul_a    = cnt_q[1] ? la_q[63:32] : la_q[31:0];
	assign mul_b    = cnt_q[0] ? lb_q[63:32] : lb_q[31:0];
	assign pp       = 64'(mul_a) * 64'(mul_b);
	assign mshift   = {1'b0, {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]}, 5'd0};

	always_comb begin
		if (neg_q) zf = {1'b0, va3d_pkg::PI_Q20} - {z_q[va3d_pkg::Z_BITS-1], z_q};
		else zf = {z_q[va3d_pkg::Z_BITS-1], z_q};
		zr = ($signed({zf[va3d_pkg::Z_BITS], zf}) + 26'sd32) >>> 6;
		if (deg_q) angle_c = va3d_pkg::HALF_PI_Q14;
		else if (zr < 0) angle_c = '0;
		else if (zr > $signed({10'd0, va3d_pkg::PI_Q14})) angle_c = va3d_pkg::PI_Q14;
		else angle_c = zr[va3d_pkg::ANGLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == 7'd3) begin
						state_q <= ST_ROOT;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_ROOT: begin
					if (cnt_q == 7'd65) begin
						state_q <= ST_CHECK;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_CHECK: begin
					if (degen) state_q <= ST_DONE;
					else state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 7'd29 || mag_q >= den_q) begin
						state_q <= ST_SIN;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_SIN: begin
					if (cnt_q == 7'd31) begin
						state_q <= ST_CORDIC;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_CORDIC: begin
					if (cnt_q == 7'(va3d_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_DONE;
						cnt_q   <= '0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (emit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q <= job_data.negative;
				mag_q <= job_data.mag;
				la_q  <= job_data.la;
				lb_q  <= job_data.lb;
			end
			ST_MUL: begin
				// four 32x32 partial products, one a cycle
				prod_q <= ((cnt_q == '0) ? '0 : prod_q) + (132'(pp) << mshift);
				rem_q  <= '0;
				den_q  <= '0;
			end
			ST_ROOT: begin
				if (rt_rem >= 70'(rt_trial)) begin
					rem_q <= 68'(rt_rem - 70'(rt_trial));
					den_q <= {den_q[64:0], 1'b1};
				end else begin
					rem_q <= 68'(rt_rem);
					den_q <= {den_q[64:0], 1'b0};
				end
				prod_q <= {prod_q[129:0], 2'b00};
			end
			ST_CHECK: begin
				r_q   <= 67'(mag_q) << 1;
				c_q   <= '0;
				deg_q <= degen;
			end
			ST_DIV: begin
				if (mag_q >= den_q) begin
					c_q <= 31'h4000_0000;
				end else begin
					c_q <= {c_q[29:0], !d_diff[67]};
					r_q <= !d_diff[67] ? 67'(d_diff) << 1 : r_q << 1;
				end
				s_q    <= '0;
				srem_q <= '0;
			end
			ST_SIN: begin
				if (cnt_q == 7'd0) begin
					sv_q   <= 62'((62'd1 << 60) - 62'(c_q) * 62'(c_q));
					srem_q <= '0;
					s_q    <= '0;
				end else begin
					if (sr_rem >= sr_trial) begin
						srem_q <= 64'(sr_rem - sr_trial);
						s_q    <= {s_q[30:0], 1'b1};
					end else begin
						srem_q <= 64'(sr_rem);
						s_q    <= {s_q[30:0], 1'b0};
					end
					sv_q <= {sv_q[59:0], 2'b00};
				end
				x_q <= va3d_pkg::CXY_BITS'(c_q);
				z_q <= '0;
			end
			ST_CORDIC: begin
				if (!ycur[va3d_pkg::CXY_BITS-1]) begin
					x_q <= x_q + dx;
					y_q <= ycur - dy;
					z_q <= z_q + va3d_pkg::atan_q20(step);
				end else begin
					x_q <= x_q - dx;
					y_q <= ycur + dy;
					z_q <= z_q - va3d_pkg::atan_q20(step);
				end
			end
			ST_DONE: begin
				if (emit) begin
					odata_q.angle      <= angle_c;
					odata_q.degenerate <= deg_q;
				end
			end
			default: ;
		endcase
	end
endmodule

[tb/sv/vector_angle_3d_unit_tb.sv]
// Testbench: random and directed vector pairs checked against a bit-exact angle predictor
`timescale 1ns / 1ps
module vector_angle_3d_unit_tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic in_valid = 1'b0;
	logic in_stall;
	va3d_pkg::va3d_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	va3d_pkg::va3d_out_t out_data;

	vector_angle_3d_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	va3d_pkg::va3d_in_t pending_words[$];
	va3d_pkg::va3d_out_t expected_angles[$];
	logic [31:0] model_threshold;
	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count;
	bit hold_sender;

	localparam logic [23:0] ATAN_TAB [0:20] = '{
		24'd823550, 24'd486170, 24'd256879, 24'd130396, 24'd65451, 24'd32757,
		24'd16383, 24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256,
		24'd128, 24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2, 24'd1
	};

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [127:0] isqrt128(input logic [127:0] v, input int top);
		logic [127:0] r;
		logic [127:0] cand;
		r = '0;
		for (int b = top; b >= 0; b--) begin
			cand = r | (128'd1 << b);
			if (cand * cand <= v)
				r = cand;
		end
		return r;
	endfunction

	function automatic va3d_pkg::va3d_out_t predict_angle(input va3d_pkg::va3d_in_t w,
			input logic [31:0] thr);
		va3d_pkg::va3d_out_t r;
		longint ax, ay, az, bx, by, bz, dot, z, x, y, dx, dy, ang;
		logic [127:0] la, lb, den, mag, c, s, rem;
		bit negative;
		ax = w.a_x; ay = w.a_y; az = w.a_z;
		bx = w.b_x; by = w.b_y; bz = w.b_z;
		dot = ax * bx + ay * by + az * bz;
		negative = dot < 0;
		mag = 128'(negative ? -dot : dot);
		la = 128'(ax * ax + ay * ay + az * az);
		lb = 128'(bx * bx + by * by + bz * bz);
		den = isqrt128(la * lb, 63);
		if (den == 0 || den < {96'd0, thr}) begin
			r.angle = va3d_pkg::HALF_PI_Q14;
			r.degenerate = 1'b1;
			return r;
		end
		if (mag >= den) begin
			c = 128'd1 << 30;
		end else begin
			c = '0;
			rem = mag;
			for (int i = 0; i < 30; i++) begin
				c = c << 1;
				if (rem >= den - rem) begin
					rem = rem - (den - rem);
					c[0] = 1'b1;
				end else begin
					rem = rem + rem;
				end
			end
		end
		s = isqrt128((128'd1 << 60) - c * c, 31);
		x = longint'(c);
		y = longint'(s);
		z = 0;
		for (int i = 0; i < 21; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end
		end
		if (negative)
			z = longint'(va3d_pkg::PI_Q20) - z;
		ang = (z + 32) >>> 6;
		if (ang < 0)
			ang = 0;
		if (ang > longint'(va3d_pkg::PI_Q14))
			ang = longint'(va3d_pkg::PI_Q14);
		r.angle = ang[15:0];
		r.degenerate = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_angles.push_back(predict_angle(in_data, model_threshold));
		end
		if (!in_valid || !in_stall) begin
			if (pending_words.size() > 0 && !hold_sender
					&& $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_words.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		va3d_pkg::va3d_out_t want;
		if (out_valid && !out_stall) begin
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected result word");
			end else begin
				want = expected_angles.pop_front();
				if (out_data.angle !== want.angle)
					report_mismatch($sformatf("angle got %0d want %0d",
						out_data.angle, want.angle));
				if (out_data.degenerate !== want.degenerate)
					report_mismatch($sformatf("degenerate got %0b want %0b",
						out_data.degenerate, want.degenerate));
			end
		end
	end

	function automatic logic [15:0] small_comp(input int lim);
		return 16'(int'($urandom_range(2 * lim)) - lim);
	endfunction

	function automatic va3d_pkg::va3d_in_t random_word(input int mode);
		va3d_pkg::va3d_in_t w;
		int lim;
		w = {$urandom, $urandom, $urandom};
		if (mode == 1) begin
			lim = $urandom_range(16, 1);
			w.a_x = small_comp(lim); w.a_y = small_comp(lim);
			w.a_z = small_comp(lim); w.b_x = small_comp(lim);
			w.b_y = small_comp(lim); w.b_z = small_comp(lim);
		end else if (mode == 2) begin
			w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
			if ($urandom_range(1)) begin
				w.b_x = -w.a_x; w.b_y = -w.a_y; w.b_z = -w.a_z;
			end
		end
		return w;
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_angles.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_threshold = v;
	endtask

	task automatic run_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n; i++)
			pending_words.push_back(random_word($urandom_range(3)));
		wait_drained();
	endtask

	initial begin
		va3d_pkg::va3d_in_t w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		model_threshold = 32'd1;
		mismatch_count = 0;
		hold_sender = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 54;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_words.push_back('0);
		pending_words.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
		pending_words.push_back({16'sd5, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 16'sd0});
		pending_words.push_back({16'sd5, 16'sd0, 16'sd0, -16'sd7, 16'sd0, 16'sd0});
		pending_words.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
		pending_words.push_back({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
		pending_words.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
		pending_words.push_back({16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0000, 16'h7fff});
		pending_words.push_back({16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back({16'sd1, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0});
		pending_words.push_back({16'sd1, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd0});
		pending_words.push_back({16'sd1, 16'sd2, 16'sd3, -16'sd3, 16'sd2, -16'sd1});
		wait_drained();

		write_threshold(32'd0);
		pending_words.push_back('0);
		pending_words.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0});
		wait_drained();
		write_threshold(32'hffffffff);
		pending_words.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
		pending_words.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0});
		wait_drained();
		write_threshold(32'd50);
		w = {16'sd7, 16'sd0, 16'sd0, 16'sd7, 16'sd1, 16'sd0};
		pending_words.push_back(w);
		w = {16'sd5, 16'sd0, 16'sd0, 16'sd9, 16'sd1, 16'sd0};
		pending_words.push_back(w);
		wait_drained();

		write_threshold(32'd1);
		run_random(350, 16, 54);
		write_threshold(32'd200);
		run_random(350, 54, 16);
		hold_sender = 1'b1;
		wait_drained();
		hold_sender = 1'b0;
		write_threshold($urandom);
		run_random(50, 0, 0);
		write_threshold(32'd0);
		run_random(300, 0, 0);

		if (mismatch_count == 0)
			$display("vector_angle_3d_unit_tb OK");
		else
			$display("vector_angle_3d_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("vector_angle_3d_unit_tb NOT OK");
		$finish;
	end
endmodule
